>>> hw/rtl/adamw_pkg.sv
// Shared types and constants of the AdamW parameter update block.
// Holds the item structs, register map and fixed-point constants.
// No dependencies.
package adamw_pkg;

  localparam int unsigned NUM_ELEMENTS = 65536;
  localparam int unsigned MEM_AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned VM_W   = 48;
  localparam int unsigned CFG_AW = 5;

  localparam logic [31:0] ONE_Q32 = 32'hFFFF_FFFF;
  localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

  localparam logic [31:0] LR_RST    = 32'd4294967;
  localparam logic [31:0] BETA1_RST = 32'd3865470566;
  localparam logic [31:0] BETA2_RST = 32'd4290672329;
  localparam logic [31:0] EPS_RST   = 32'd43;
  localparam logic [31:0] DECAY_RST = 32'd42949673;

  typedef enum logic [2:0] {
    REG_LR    = 3'd0,
    REG_BETA1 = 3'd1,
    REG_BETA2 = 3'd2,
    REG_EPS   = 3'd3,
    REG_DECAY = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_UPDATE     = 1'b0,
    OP_BEGIN_STEP = 1'b1
  } op_e;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        element_index;
    logic signed [DATA_W-1:0] param_value;
    logic signed [DATA_W-1:0] gradient;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] new_param_value;
  } out_item_t;

endpackage

>>> hw/rtl/adamw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old contents.
// No dependencies.
module adamw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/adamw_parameter_update.sv
// AdamW parameter update, top level: config registers, moment stores,
// the pipelined update datapath and the output skid stage.
// Depends on adamw_pkg and adamw_ram.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_item_i): an item with op set
//   begins a new optimizer step (powers of beta advance, no result); an item
//   with op clear updates one element and gives one result.
// - Output channel (out_valid_o / out_stall_i / out_item_o): one result per
//   element update, in input order.
// - Throughput: one item per cycle while in_stall_o is low. The datapath is
//   pipelined through the two divider chains (2 quotient bits per stage)
//   and the square root (2 root bits per stage) between them.
// - Reset: registers take their reset values, then a clearing pass zeroes
//   all NUM_ELEMENTS (65536) entries of both moment stores, one entry per
//   cycle; in_stall_o stays high during the pass. APB writes are taken throughout.
// - When the receiver stalls, a skid register catches the item in flight;
//   the pipeline and the input then stall until the skid drains.
// - Registers are written over APB at byte address 4*i; write only while idle.
module adamw_parameter_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  adamw_pkg::in_item_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output adamw_pkg::out_item_t          out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [adamw_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import adamw_pkg::*;

  localparam int unsigned STEPS      = 2;
  localparam int unsigned DIV_STAGES = 64 / STEPS;
  localparam int unsigned SQ_STAGES  = 32 / STEPS;
  localparam int unsigned SD_STAGES  = 42 / STEPS;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic signed [31:0] g;
    logic [31:0]       bc1;
    logic [31:0]       bc2;
  } a_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic [47:0]       g2;
    logic signed [63:0] cg;
    logic [31:0]       bc1;
    logic [31:0]       bc2;
  } b_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic signed [63:0] cg;
    logic [63:0]       ylo;
    logic [47:0]       yhi;
    logic [31:0]       bc1;
    logic [31:0]       bc2;
  } c_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic signed [31:0] m;
    logic [47:0]       v;
    logic [31:0]       bc1;
    logic [31:0]       bc2;
  } d_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] m;
    logic [47:0]       v;
  } fwd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic [31:0]       r1;
    logic [63:0]       q1;
    logic [31:0]       d1;
    logic [31:0]       r2;
    logic [63:0]       q2;
    logic [31:0]       d2;
    logic              sat2;
  } dv_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic [63:0]       mhat;
    logic [63:0]       rad;
    logic [33:0]       rem;
    logic [31:0]       root;
  } sq_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic [31:0]       mhat_hi;
    logic [63:0]       p0;
    logic [40:0]       denom;
  } m1_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic [63:0]       p0;
    logic [63:0]       p1;
    logic [40:0]       denom;
  } m2_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic [95:0]       num;
    logic [40:0]       denom;
  } m3_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic signed [31:0] theta;
    logic              neg;
    logic              sat;
    logic              zero;
    logic [40:0]       rem;
    logic [41:0]       nq;
    logic [40:0]       d;
  } sd_t;

  // One restoring division step, 32-bit divisor.
  function automatic logic [95:0] div32_step(logic [31:0] rem, logic [63:0] nq,
                                             logic [31:0] d);
    logic [32:0] t;
    logic        qb;
    t  = {rem, nq[63]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    return {t[31:0], nq[62:0], qb};
  endfunction

  // One restoring division step, 41-bit divisor.
  function automatic logic [82:0] div41_step(logic [40:0] rem, logic [41:0] nq,
                                             logic [40:0] d);
    logic [41:0] t;
    logic        qb;
    t  = {rem, nq[41]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    return {t[40:0], nq[40:0], qb};
  endfunction

  // One digit of the integer square root.
  function automatic logic [129:0] sqrt_step(logic [33:0] rem, logic [63:0] rad,
                                             logic [31:0] root);
    logic [35:0] t;
    logic [35:0] trial;
    logic        rb;
    t     = {rem, rad[63:62]};
    trial = {2'b00, root, 2'b01};
    rb    = (t >= trial);
    if (rb) begin
      t = t - trial;
    end
    return {t[33:0], rad[61:0], 2'b00, root[30:0], rb};
  endfunction

  function automatic logic [31:0] bias_corr(logic [31:0] pow);
    logic [31:0] bc;
    bc = ONE_Q32 - pow;
    if (bc == 32'd0) begin
      bc = 32'd1;
    end
    return bc;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [31:0] lr_q, beta1_q, beta2_q, eps_q, lambda_q;
  logic [31:0] decay_fac_q;
  logic [63:0] lr_lambda;
  logic        cfg_wr;
  logic [2:0]  cfg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q     <= LR_RST;
      beta1_q  <= BETA1_RST;
      beta2_q  <= BETA2_RST;
      eps_q    <= EPS_RST;
      lambda_q <= DECAY_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_LR:    lr_q     <= pwdata;
        REG_BETA1: beta1_q  <= pwdata;
        REG_BETA2: beta2_q  <= pwdata;
        REG_EPS:   eps_q    <= pwdata;
        REG_DECAY: lambda_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_LR:    prdata = lr_q;
      REG_BETA1: prdata = beta1_q;
      REG_BETA2: prdata = beta2_q;
      REG_EPS:   prdata = eps_q;
      REG_DECAY: prdata = lambda_q;
      default:   prdata = 32'd0;
    endcase
  end

  assign lr_lambda = 64'(lr_q) * 64'(lambda_q);

  always_ff @(posedge clk_i) begin
    decay_fac_q <= ONE_Q32 - lr_lambda[63:32];
  end

  // ---------------------------------------------------------------------------
  // Handshake, step powers, clearing pass
  logic             clearing_q;
  logic [MEM_AW-1:0] clr_cnt_q;
  logic             skid_vld_q;
  logic             adv;
  logic             acc;
  logic             idx_ok;
  logic [31:0]      b1pow_q, b2pow_q;
  logic [63:0]      b1pow_prod, b2pow_prod;

  assign adv        = !skid_vld_q;
  assign in_stall_o = clearing_q || skid_vld_q;
  assign acc        = in_valid_i && !in_stall_o;
  assign idx_ok     = {16'd0, in_item_i.element_index} < 32'(NUM_ELEMENTS);
  assign b1pow_prod = 64'(b1pow_q) * 64'(beta1_q);
  assign b2pow_prod = 64'(b2pow_q) * 64'(beta2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1pow_q    <= ONE_Q32;
      b2pow_q    <= ONE_Q32;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (acc && in_item_i.op == OP_BEGIN_STEP) begin
        b1pow_q <= b1pow_prod[63:32];
        b2pow_q <= b2pow_prod[63:32];
      end
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == MEM_AW'(NUM_ELEMENTS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages: products that do not depend on the stored moments
  a_t   a_q;
  b_t   b_q;
  c_t   c_q;
  d_t   d_q;
  fwd_t e_q;
  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;

  logic signed [63:0] a_gg, a_cg, a_td;
  logic [63:0]        b_ylo;
  logic [47:0]        b_yhi;
  logic [31:0]        c2;

  assign a_gg = 64'(a_q.g) * 64'(a_q.g);
  assign a_cg = 64'(signed'({1'b0, ONE_Q32 - beta1_q})) * 64'(a_q.g);
  assign a_td = 64'(a_q.theta) * 64'(signed'({1'b0, decay_fac_q}));
  assign c2    = ONE_Q32 - beta2_q;
  assign b_ylo = 64'(c2) * 64'(b_q.g2[31:0]);
  assign b_yhi = 48'(c2) * 48'(b_q.g2[47:32]);

  // Moment stores
  logic [31:0]       ram_m_rdata;
  logic [47:0]       ram_v_rdata;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [31:0]       ram_m_wdata;
  logic [47:0]       ram_v_wdata;

  assign ram_we      = clearing_q || (adv && d_vld_q);
  assign ram_waddr   = clearing_q ? clr_cnt_q : MEM_AW'(d_q.idx);
  assign ram_m_wdata = clearing_q ? 32'd0 : d_q.m;
  assign ram_v_wdata = clearing_q ? 48'd0 : d_q.v;

  adamw_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ELEMENTS)) u_m_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_m_wdata),
    .re_i    (adv),
    .raddr_i (MEM_AW'(b_q.idx)),
    .rdata_o (ram_m_rdata)
  );

  adamw_ram #(.WIDTH(VM_W), .DEPTH(NUM_ELEMENTS)) u_v_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_v_wdata),
    .re_i    (adv),
    .raddr_i (MEM_AW'(b_q.idx)),
    .rdata_o (ram_v_rdata)
  );

  // Moment update; take the newest value of the index from the two
  // stages whose writes the read did not see.
  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic signed [63:0] m_prod;
  logic [64:0]        v_lo;
  logic [48:0]        v_hi;
  logic [47:0]        v_new;

  always_comb begin
    if (d_vld_q && d_q.idx == c_q.idx) begin
      m_old = d_q.m;
      v_old = d_q.v;
    end else if (e_vld_q && e_q.idx == c_q.idx) begin
      m_old = e_q.m;
      v_old = e_q.v;
    end else begin
      m_old = signed'(ram_m_rdata);
      v_old = ram_v_rdata;
    end
  end

  assign m_prod = 64'(signed'({1'b0, beta1_q})) * 64'(m_old) + c_q.cg;
  assign v_lo   = 65'(64'(beta2_q) * 64'(v_old[31:0])) + 65'(c_q.ylo);
  assign v_hi   = 49'(48'(beta2_q) * 48'(v_old[47:32])) + 49'(c_q.yhi);
  assign v_new  = 48'(50'(v_hi) + 50'(v_lo[64:32]));

  // Division setup
  logic [31:0] d_mmag;
  logic [31:0] d_vtop;
  dv_t         dv_init;

  assign d_mmag = d_q.m[31] ? 32'(-33'(d_q.m)) : 32'(d_q.m);
  assign d_vtop = d_q.v[47:16];

  always_comb begin
    dv_init.idx   = d_q.idx;
    dv_init.theta = d_q.theta;
    dv_init.neg   = d_q.m[31];
    dv_init.r1    = 32'd0;
    dv_init.q1    = {d_mmag, 32'd0};
    dv_init.d1    = d_q.bc1;
    dv_init.r2    = d_vtop;
    dv_init.q2    = {d_q.v[15:0], 48'd0};
    dv_init.d2    = d_q.bc2;
    dv_init.sat2  = (d_vtop >= d_q.bc2);
  end

  dv_t  dv_q   [0:DIV_STAGES];
  logic dv_vld_q [0:DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      c_vld_q    <= 1'b0;
      d_vld_q    <= 1'b0;
      e_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      a_vld_q    <= acc && in_item_i.op == OP_UPDATE && idx_ok;
      b_vld_q    <= a_vld_q;
      c_vld_q    <= b_vld_q;
      d_vld_q    <= c_vld_q;
      e_vld_q    <= d_vld_q;
      dv_vld_q[0] <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q.idx   <= in_item_i.element_index;
      a_q.theta <= in_item_i.param_value;
      a_q.g     <= in_item_i.gradient;
      a_q.bc1   <= bias_corr(b1pow_q);
      a_q.bc2   <= bias_corr(b2pow_q);

      b_q.idx   <= a_q.idx;
      b_q.theta <= a_td[63:32];
      b_q.g2    <= a_gg[63:16];
      b_q.cg    <= a_cg;
      b_q.bc1   <= a_q.bc1;
      b_q.bc2   <= a_q.bc2;

      c_q.idx   <= b_q.idx;
      c_q.theta <= b_q.theta;
      c_q.cg    <= b_q.cg;
      c_q.ylo   <= b_ylo;
      c_q.yhi   <= b_yhi;
      c_q.bc1   <= b_q.bc1;
      c_q.bc2   <= b_q.bc2;

      d_q.idx   <= c_q.idx;
      d_q.theta <= c_q.theta;
      d_q.m     <= m_prod[63:32];
      d_q.v     <= v_new;
      d_q.bc1   <= c_q.bc1;
      d_q.bc2   <= c_q.bc2;

      e_q.idx   <= d_q.idx;
      e_q.m     <= d_q.m;
      e_q.v     <= d_q.v;

      dv_q[0]   <= dv_init;
    end
  end

  // ---------------------------------------------------------------------------
  // Corrected moments: two dividers side by side
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    dv_t nxt;

    always_comb begin
      nxt = dv_q[s];
      for (int k = 0; k < STEPS; k++) begin
        {nxt.r1, nxt.q1} = div32_step(nxt.r1, nxt.q1, nxt.d1);
        {nxt.r2, nxt.q2} = div32_step(nxt.r2, nxt.q2, nxt.d2);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[s+1] <= dv_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[s+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of the corrected second moment
  sq_t  sq_q   [0:SQ_STAGES];
  logic sq_vld_q [0:SQ_STAGES];
  sq_t  sq_init;

  always_comb begin
    sq_init.idx   = dv_q[DIV_STAGES].idx;
    sq_init.theta = dv_q[DIV_STAGES].theta;
    sq_init.neg   = dv_q[DIV_STAGES].neg;
    sq_init.mhat  = dv_q[DIV_STAGES].q1;
    sq_init.rad   = dv_q[DIV_STAGES].sat2 ? {64{1'b1}} : dv_q[DIV_STAGES].q2;
    sq_init.rem   = 34'd0;
    sq_init.root  = 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (adv) begin
      sq_vld_q[0] <= dv_vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_init;
    end
  end

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
    sq_t nxt;

    always_comb begin
      nxt = sq_q[s];
      for (int k = 0; k < STEPS; k++) begin
        {nxt.rem, nxt.rad, nxt.root} = sqrt_step(nxt.rem, nxt.rad, nxt.root);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[s+1] <= sq_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[s+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // lr * mhat in two partial products, then the step division setup
  m1_t         m1_q;
  m2_t         m2_q;
  m3_t         m3_q;
  logic        m1_vld_q, m2_vld_q, m3_vld_q;
  sq_t         sq_last;
  sd_t         sd_init;

  assign sq_last = sq_q[SQ_STAGES];

  always_comb begin
    sd_init.idx   = m3_q.idx;
    sd_init.theta = m3_q.theta;
    sd_init.neg   = m3_q.neg;
    sd_init.zero  = (m3_q.num == 96'd0);
    sd_init.sat   = (m3_q.denom == 41'd0) ||
                    (m3_q.num[95:42] >= 54'(m3_q.denom));
    sd_init.rem   = m3_q.num[82:42];
    sd_init.nq    = m3_q.num[41:0];
    sd_init.d     = m3_q.denom;
  end

  sd_t  sd_q   [0:SD_STAGES];
  logic sd_vld_q [0:SD_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q    <= 1'b0;
      m2_vld_q    <= 1'b0;
      m3_vld_q    <= 1'b0;
      sd_vld_q[0] <= 1'b0;
    end else if (adv) begin
      m1_vld_q    <= sq_vld_q[SQ_STAGES];
      m2_vld_q    <= m1_vld_q;
      m3_vld_q    <= m2_vld_q;
      sd_vld_q[0] <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q.idx     <= sq_last.idx;
      m1_q.theta   <= sq_last.theta;
      m1_q.neg     <= sq_last.neg;
      m1_q.mhat_hi <= sq_last.mhat[63:32];
      m1_q.p0      <= 64'(sq_last.mhat[31:0]) * 64'(lr_q);
      m1_q.denom   <= {1'b0, sq_last.root, 8'd0} + 41'(eps_q);

      m2_q.idx     <= m1_q.idx;
      m2_q.theta   <= m1_q.theta;
      m2_q.neg     <= m1_q.neg;
      m2_q.p0      <= m1_q.p0;
      m2_q.p1      <= 64'(m1_q.mhat_hi) * 64'(lr_q);
      m2_q.denom   <= m1_q.denom;

      m3_q.idx     <= m2_q.idx;
      m3_q.theta   <= m2_q.theta;
      m3_q.neg     <= m2_q.neg;
      m3_q.num     <= 96'(m2_q.p0) + {m2_q.p1, 32'd0};
      m3_q.denom   <= m2_q.denom;

      sd_q[0]      <= sd_init;
    end
  end

  for (genvar s = 0; s < SD_STAGES; s++) begin : g_step_div
    sd_t nxt;

    always_comb begin
      nxt = sd_q[s];
      for (int k = 0; k < STEPS; k++) begin
        {nxt.rem, nxt.nq} = div41_step(nxt.rem, nxt.nq, nxt.d);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        sd_vld_q[s+1] <= sd_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q[s+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Apply the capped step and saturate
  sd_t                sd_last;
  logic [40:0]        step;
  logic signed [42:0] res_wide;
  logic signed [31:0] res;
  out_item_t          last_q;
  logic               last_vld_q;

  assign sd_last = sd_q[SD_STAGES];

  always_comb begin
    if (sd_last.zero) begin
      step = 41'd0;
    end else if (sd_last.sat || sd_last.nq > 42'(STEP_CAP)) begin
      step = STEP_CAP;
    end else begin
      step = sd_last.nq[40:0];
    end
    if (sd_last.neg) begin
      res_wide = 43'(sd_last.theta) + signed'({2'b00, step});
    end else begin
      res_wide = 43'(sd_last.theta) - signed'({2'b00, step});
    end
    if (res_wide > 43'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (res_wide < -43'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = res_wide[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_vld_q <= 1'b0;
    end else if (adv) begin
      last_vld_q <= sd_vld_q[SD_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q.result_index    <= sd_last.idx;
      last_q.new_param_value <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid
  out_item_t out_q, skid_q;
  logic      out_vld_q;
  logic      out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || last_vld_q;
      skid_vld_q <= 1'b0;
    end else if (last_vld_q) begin
      // hold the arriving item while the receiver stalls
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : last_q;
    end else if (adv) begin
      skid_q <= last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

>>> tb/adamw_parameter_update_test.sv
// Self-checking testbench for the AdamW parameter update block.
// A directed table and random items with random stalls, checked against a local predictor.
// Depends on adamw_pkg and adamw_parameter_update.
`timescale 1ns / 1ps

module adamw_parameter_update_test;
  import adamw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RAND_PER_PHASE = 347;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_item_t in_item_i;
  out_item_t out_item_o;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  adamw_parameter_update DUT (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // predictor state
  logic [31:0] lr_q, beta1_q, beta2_q, eps_q, lambda_q;
  logic [31:0] beta1_pow, beta2_pow;
  logic signed [31:0] mom1_store [NUM_ELEMENTS];
  logic [47:0] mom2_store [NUM_ELEMENTS];

  out_item_t pending_params [$];
  int unsigned errors, results_seen, items_sent, cycles, steps_begun;
  bit tx_gaps, rx_calm;
  int unsigned stall_left;

  typedef struct packed {
    logic op;
    logic [15:0] idx;
    logic [31:0] param;
    logic [31:0] grad;
    logic typed;
    logic [31:0] typed_value;
  } stim_row_t;

  function automatic logic [63:0] sat_quot(logic [127:0] num, logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return (num != 0) ? '1 : '0;
    q = num / d;
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [31:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if (64'(t) * 64'(t) <= x) r = t;
    end
    return r;
  endfunction

  // Advance the moments of one element and return its new parameter.
  function automatic logic [31:0] adamw_new_param(logic [15:0] idx, logic [31:0] theta,
                                                   logic [31:0] g);
    logic [31:0] decay, bc1, bc2;
    logic [63:0] lrl;
    logic signed [63:0] th;
    logic signed [95:0] pr;
    logic signed [31:0] m;
    logic signed [63:0] gsq;
    logic [63:0] g2, mhat, vhat, denom, step;
    logic [95:0] vx;
    logic [47:0] v;
    longint mm, res;
    lrl = 64'(lr_q) * 64'(lambda_q);
    decay = ONE_Q32 - lrl[63:32];
    th = $signed(theta) * $signed({1'b0, decay});
    th = th >>> 32;
    pr = $signed(mom1_store[idx]) * $signed({1'b0, beta1_q})
       + $signed(g) * $signed({1'b0, ONE_Q32 - beta1_q});
    pr = pr >>> 32;
    m = pr[31:0];
    mom1_store[idx] = m;
    gsq = $signed(g) * $signed(g);
    g2 = gsq >> 16;
    vx = 96'(beta2_q) * 96'(mom2_store[idx]) + 96'(ONE_Q32 - beta2_q) * 96'(g2);
    v = vx[79:32];
    mom2_store[idx] = v;
    bc1 = ONE_Q32 - beta1_pow;
    bc2 = ONE_Q32 - beta2_pow;
    if (bc1 == 0) bc1 = 32'd1;
    if (bc2 == 0) bc2 = 32'd1;
    mm = m;
    if (mm < 0) mm = -mm;
    mhat = sat_quot(128'(mm) << 32, 64'(bc1));
    vhat = sat_quot(128'(v) << 48, 64'(bc2));
    denom = (64'(root64(vhat)) << 8) + 64'(eps_q);
    step = sat_quot(128'(mhat) * 128'(lr_q), denom);
    if (step > 64'(STEP_CAP)) step = 64'(STEP_CAP);
    res = (m < 0) ? th + longint'(step) : th - longint'(step);
    if (res > 64'sh7FFF_FFFF) res = 64'sh7FFF_FFFF;
    if (res < -64'sh8000_0000) res = -64'sh8000_0000;
    return res[31:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0t] mismatch %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_params.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls: short and long bursts, with calm stretches
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_calm || r < 70) begin
      out_stall_i <= 1'b0;
    end else if (r < 96) begin
      stall_left <= $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      stall_left <= $urandom_range(15, 50);
      out_stall_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_params.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_item_o.result_index),
                        out_item_o.new_param_value);
      end else begin
        want = pending_params.pop_front();
        if (out_item_o.result_index != want.result_index)
          report_mismatch("result_index", 32'(out_item_o.result_index),
                          32'(want.result_index));
        if (out_item_o.new_param_value != want.new_param_value)
          report_mismatch("new_param_value", out_item_o.new_param_value,
                          want.new_param_value);
      end
    end
  end

  task automatic cfg_write(input cfg_reg_e reg_id, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(reg_id) << 2;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (reg_id)
      REG_LR:    lr_q = value;
      REG_BETA1: beta1_q = value;
      REG_BETA2: beta2_q = value;
      REG_EPS:   eps_q = value;
      REG_DECAY: lambda_q = value;
      default: ;
    endcase
    // idle cycle between transfers
    @(posedge clk_i);
  endtask

  task automatic cfg_all(input logic [31:0] lr, b1, b2, eps, lambda);
    cfg_write(REG_LR, lr);
    cfg_write(REG_BETA1, b1);
    cfg_write(REG_BETA2, b2);
    cfg_write(REG_EPS, eps);
    cfg_write(REG_DECAY, lambda);
  endtask

  // Drive one item, hold it until taken, then record what it should produce.
  task automatic send_item(input stim_row_t row);
    out_item_t want;
    int unsigned r, gap;
    in_valid_i <= 1'b1;
    in_item_i.op <= row.op;
    in_item_i.element_index <= row.idx;
    in_item_i.param_value <= row.param;
    in_item_i.gradient <= row.grad;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (row.op == OP_BEGIN_STEP) begin
      beta1_pow = 32'((64'(beta1_pow) * 64'(beta1_q)) >> 32);
      beta2_pow = 32'((64'(beta2_pow) * 64'(beta2_q)) >> 32);
      steps_begun++;
    end else begin
      want.result_index = row.idx;
      want.new_param_value = adamw_new_param(row.idx, row.param, row.grad);
      if (row.typed) want.new_param_value = row.typed_value;
      pending_params.push_back(want);
    end
    r = $urandom_range(0, 99);
    gap = 0;
    if (tx_gaps) begin
      if (r >= 90) gap = $urandom_range(20, 60);
      else if (r >= 80) gap = $urandom_range(4, 10);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_q824();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    if (r < 45) return 32'($signed($urandom_range(0, 6)) - 3);
    return 32'($signed($urandom) >>> $urandom_range(4, 14));
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t row;
    row = '0;
    row.op = ($urandom_range(0, 99) < 6) ? OP_BEGIN_STEP : OP_UPDATE;
    row.idx = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(0, 31)) : 16'($urandom);
    row.param = rand_q824();
    row.grad = rand_q824();
    return row;
  endfunction

  task automatic wait_idle();
    while (pending_params.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase();
    for (int i = 0; i < RAND_PER_PHASE; i++) begin
      if (i % 100 == 0) begin
        tx_gaps = $urandom_range(0, 2) != 0;
        rx_calm = $urandom_range(0, 3) == 0;
      end
      send_item(rand_row());
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  stim_row_t stim_rows [] = '{
    // fresh element, nothing to move: zero out
    '{OP_UPDATE,     16'd0,     32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0},
    // no step begun yet: corrections saturate
    '{OP_UPDATE,     16'd65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd1,     32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd2,     32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd3,     32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{OP_BEGIN_STEP, 16'd0,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd0,     32'h0100_0000, 32'h0100_0000, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_BEGIN_STEP, 16'hFFFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_BEGIN_STEP, 16'd7,     32'h1234_5678, 32'h8765_4321, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd4,     32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0},
    '{OP_UPDATE,     16'd1,     32'hFF00_0000, 32'h0000_0001, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd2,     32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{OP_UPDATE,     16'hAAAA,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
    '{OP_UPDATE,     16'h5555,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd3,     32'h0080_0000, 32'hFF80_0000, 1'b0, 32'h0},
    '{OP_BEGIN_STEP, 16'd0,     32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
    '{OP_UPDATE,     16'd0,     32'h0200_0000, 32'hFE00_0000, 1'b0, 32'h0}
  };

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    results_seen = 0;
    items_sent = 0;
    cycles = 0;
    steps_begun = 0;
    stall_left = 0;
    tx_gaps = 1'b1;
    rx_calm = 1'b0;
    lr_q = LR_RST;
    beta1_q = BETA1_RST;
    beta2_q = BETA2_RST;
    eps_q = EPS_RST;
    lambda_q = DECAY_RST;
    beta1_pow = ONE_Q32;
    beta2_pow = ONE_Q32;
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      mom1_store[i] = '0;
      mom2_store[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first, with the directed rows
    foreach (stim_rows[i]) send_item(stim_rows[i]);
    random_phase();
    wait_idle();

    cfg_all('1, '1, '1, '1, '1);
    random_phase();
    wait_idle();

    // all zero: zero denominator shows up with tiny gradients
    cfg_all('0, '0, '0, '0, '0);
    random_phase();
    wait_idle();

    cfg_all($urandom, $urandom, $urandom, $urandom_range(0, 1000), $urandom);
    random_phase();
    wait_idle();

    cfg_all(32'd42949673, 32'd3865470566, 32'd4290672329, 32'd0, 32'd429496730);
    random_phase();
    wait_idle();

    $display("%0d items sent (%0d step starts), %0d results checked over 5 register settings",
             items_sent, steps_begun, results_seen);
    $display("%0d mismatches", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
